// ===== hw/rtl/phc_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the probed hash cache
package phc_pkg;

	// table geometry
	localparam int TABLE_SIZE  = 32;
	localparam int PROBE_LEN   = 3;
	localparam int IDX_W       = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int PRB_W       = (PROBE_LEN > 1) ? $clog2(PROBE_LEN) : 1;
	localparam bit IS_POW2     = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	// field widths
	localparam int MODE_W   = 2;
	localparam int ID_W     = 16;
	localparam int BCI_W    = 16;
	localparam int LOC_W    = 16;
	localparam int CSZ_W    = 16;
	localparam int PRM_W    = 8;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 5;
	localparam int CNT_W    = 6;
	localparam int KEY_W    = ID_W + BCI_W;

	// hash word: widest term is code_bytes << 4
	localparam int HASH_W    = CSZ_W + 4;
	localparam int MOD_STEPS = (HASH_W + 3) / 4;
	localparam int MOD_W     = MOD_STEPS * 4;
	localparam int MSTEP_W   = $clog2(MOD_STEPS + 1);

	// item modes
	localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INV_METHOD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INV_ALL    = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSTALL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REPLACE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SKIP    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVAL   = 3'd4;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic hash_go;
		logic probe_start;
		logic probe_step;
		logic walk_start;
		logic walk_step;
		logic fin_hit;
		logic fin_miss;
		logic fin_walk;
		logic fin_nop;
	} phc_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic hash_rdy;
		logic hit;
		logic walk_last;
	} phc_stat_t;

endpackage

// ===== hw/rtl/probed_hash_cache_policy_core.sv =====
// top level of the probed hash cache slot policy: controller plus datapath
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------------
//  item in  | start & !busy      | mode, method_id, bci, local_slots, code_bytes,
//           |                    | param_count, no_install
//  result   | done (one cycle)   | status, slot, evicted_valid, evicted_method,
//           |                    | evicted_bci, invalidated_count
//
// lookup: the hash is reduced to a base index (a mask for a power-of-two table, otherwise a
//   remainder taken four hash bits at a time), then up to PROBE_LEN slots are probed in turn
//   through the single key memory read port; done follows the last probe.
// invalidate: walks all TABLE_SIZE slots one a cycle; done follows the last slot.
// reserved mode: done on the cycle after accept.
// reset empties the table at once through the valid bits; no clearing pass.
// results are not held: done is high for exactly one cycle per item.
module probed_hash_cache_policy_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [phc_pkg::MODE_W-1:0]   mode,
	input  logic [phc_pkg::ID_W-1:0]     method_id,
	input  logic [phc_pkg::BCI_W-1:0]    bci,
	input  logic [phc_pkg::LOC_W-1:0]    local_slots,
	input  logic [phc_pkg::CSZ_W-1:0]    code_bytes,
	input  logic [phc_pkg::PRM_W-1:0]    param_count,
	input  logic                         no_install,
	output logic                         done,
	output logic [phc_pkg::STATUS_W-1:0] status,
	output logic [phc_pkg::SLOT_W-1:0]   slot,
	output logic                         evicted_valid,
	output logic [phc_pkg::ID_W-1:0]     evicted_method,
	output logic [phc_pkg::BCI_W-1:0]    evicted_bci,
	output logic [phc_pkg::CNT_W-1:0]    invalidated_count
);
	import phc_pkg::*;

	phc_cmd_t  cmd;
	phc_stat_t stat;

	// sequencing
	phc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage and evaluation
	phc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.mode              (mode),
		.method_id         (method_id),
		.bci               (bci),
		.local_slots       (local_slots),
		.code_bytes        (code_bytes),
		.param_count       (param_count),
		.no_install        (no_install),
		.done              (done),
		.status            (status),
		.slot              (slot),
		.evicted_valid     (evicted_valid),
		.evicted_method    (evicted_method),
		.evicted_bci       (evicted_bci),
		.invalidated_count (invalidated_count)
	);

endmodule

// ===== hw/rtl/phc_ctrl.sv =====
// controller state machine sequencing hash, probe and invalidation walk
module phc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [phc_pkg::MODE_W-1:0] mode,
	input  phc_pkg::phc_stat_t         stat,
	output phc_pkg::phc_cmd_t          cmd,
	output logic                       busy
);
	import phc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_HASH  = 4'b0010,
		S_PROBE = 4'b0100,
		S_WALK  = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [PRB_W-1:0]  prb_q, prb_d;

	assign busy = (state_q != S_IDLE);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		prb_d   = prb_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (mode)
						MODE_LOOKUP: begin
							state_d = S_HASH;
						end
						MODE_INV_METHOD, MODE_INV_ALL: begin
							cmd.walk_start = 1'b1;
							state_d        = S_WALK;
						end
						default: begin
							cmd.fin_nop = 1'b1;
						end
					endcase
				end
			end
			S_HASH: begin
				cmd.hash_go = 1'b1;
				if (stat.hash_rdy) begin
					cmd.probe_start = 1'b1;
					prb_d           = '0;
					state_d         = S_PROBE;
				end
			end
			S_PROBE: begin
				cmd.probe_step = 1'b1;
				if (stat.hit) begin
					cmd.fin_hit = 1'b1;
					state_d     = S_IDLE;
				end else if (prb_q == PRB_W'(PROBE_LEN - 1)) begin
					cmd.fin_miss = 1'b1;
					state_d      = S_IDLE;
				end else begin
					prb_d = prb_q + PRB_W'(1);
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_last) begin
					cmd.fin_walk = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prb_q   <= '0;
		end else begin
			state_q <= state_d;
			prb_q   <= prb_d;
		end
	end

endmodule

// ===== hw/rtl/phc_dp.sv =====
// datapath: key memory, valid bits, hash reduction, probe and walk evaluation, result registers
module phc_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  phc_pkg::phc_cmd_t            cmd,
	output phc_pkg::phc_stat_t           stat,
	input  logic [phc_pkg::MODE_W-1:0]   mode,
	input  logic [phc_pkg::ID_W-1:0]     method_id,
	input  logic [phc_pkg::BCI_W-1:0]    bci,
	input  logic [phc_pkg::LOC_W-1:0]    local_slots,
	input  logic [phc_pkg::CSZ_W-1:0]    code_bytes,
	input  logic [phc_pkg::PRM_W-1:0]    param_count,
	input  logic                         no_install,
	output logic                         done,
	output logic [phc_pkg::STATUS_W-1:0] status,
	output logic [phc_pkg::SLOT_W-1:0]   slot,
	output logic                         evicted_valid,
	output logic [phc_pkg::ID_W-1:0]     evicted_method,
	output logic [phc_pkg::BCI_W-1:0]    evicted_bci,
	output logic [phc_pkg::CNT_W-1:0]    invalidated_count
);
	import phc_pkg::*;

	// item registers
	logic [KEY_W-1:0]    key_q;
	logic                all_q;
	logic                skip_q;

	// table storage
	logic [KEY_W-1:0]    key_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] valid_q;
	logic [KEY_W-1:0]    rdata_q;

	// probe / walk state
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_nxt;
	logic [IDX_W-1:0]    base;
	logic                emp_found_q;
	logic [IDX_W-1:0]    emp_idx_q;
	logic [KEY_W-1:0]    evict_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_nxt;

	// read port control
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;

	// slot evaluation
	logic                cur_valid;
	logic                cur_empty;
	logic                any_empty;
	logic [IDX_W-1:0]    fill_idx;
	logic [KEY_W-1:0]    old_key;
	logic                walk_match;

	// result registers
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                ev_valid_q;
	logic [KEY_W-1:0]    ev_key_q;
	logic [CNT_W-1:0]    count_q;

	// hash of the incoming item
	logic [HASH_W-1:0]   hash_in;
	assign hash_in = HASH_W'(bci) ^ (HASH_W'(local_slots) << 2) ^
	                 (HASH_W'(code_bytes) << 4) ^ (HASH_W'(param_count) << 6);

	// hash reduction to a table index
	generate
		if (IS_POW2) begin : g_mask
			logic [IDX_W-1:0] base_q;
			always_ff @(posedge clk) begin
				if (cmd.load) begin
					base_q <= hash_in[IDX_W-1:0];
				end
			end
			assign base          = base_q;
			assign stat.hash_rdy = 1'b1;
		end else begin : g_mod
			// four hash bits per cycle, msb first, restoring remainder
			logic [MOD_W-1:0]   sh_q;
			logic [IDX_W-1:0]   rem_q;
			logic [MSTEP_W-1:0] steps_q;
			logic [IDX_W-1:0]   rem_nxt;
			logic               rdy;

			assign rdy = (steps_q == '0);

			always_comb begin
				logic [IDX_W:0]   t;
				logic [IDX_W-1:0] r;
				r = rem_q;
				for (int j = 0; j < 4; j++) begin
					t = {r, sh_q[MOD_W-1-j]};
					if (t >= (IDX_W+1)'(TABLE_SIZE)) begin
						t = t - (IDX_W+1)'(TABLE_SIZE);
					end
					r = t[IDX_W-1:0];
				end
				rem_nxt = r;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					steps_q <= '0;
				end else if (cmd.load) begin
					steps_q <= MSTEP_W'(MOD_STEPS);
				end else if (cmd.hash_go && !rdy) begin
					steps_q <= steps_q - MSTEP_W'(1);
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.load) begin
					sh_q  <= MOD_W'(hash_in);
					rem_q <= '0;
				end else if (cmd.hash_go && !rdy) begin
					sh_q  <= sh_q << 4;
					rem_q <= rem_nxt;
				end
			end

			assign base          = rem_q;
			assign stat.hash_rdy = rdy;
		end
	endgenerate

	// slot walk and wrap
	assign idx_nxt = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + IDX_W'(1);
	assign stat.walk_last = (idx_q == IDX_W'(TABLE_SIZE - 1));

	// current slot checks
	assign cur_valid  = valid_q[idx_q];
	assign cur_empty  = !cur_valid;
	assign stat.hit   = cur_valid && (rdata_q == key_q);
	assign any_empty  = emp_found_q || cur_empty;
	assign fill_idx   = emp_found_q ? emp_idx_q : idx_q;
	assign old_key    = (idx_q == base) ? rdata_q : evict_q;
	assign walk_match = cur_valid && (all_q || (rdata_q[KEY_W-1:BCI_W] == key_q[KEY_W-1:BCI_W]));
	assign cnt_nxt    = (walk_match && cnt_q != '1) ? cnt_q + CNT_W'(1) : cnt_q;

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_nxt;
		if (cmd.probe_start) begin
			rd_en   = 1'b1;
			rd_addr = base;
		end else if (cmd.walk_start) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if (cmd.probe_step || cmd.walk_step) begin
			rd_en   = 1'b1;
			rd_addr = idx_nxt;
		end
	end

	assign wr_en   = cmd.fin_miss && !skip_q;
	assign wr_addr = any_empty ? fill_idx : base;

	// key memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= key_q;
		end
		if (rd_en) begin
			rdata_q <= key_mem[rd_addr];
		end
	end

	// valid bits and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (cmd.walk_step && walk_match) begin
				valid_q[idx_q] <= 1'b0;
			end
			done_q <= cmd.fin_hit || cmd.fin_miss || cmd.fin_walk || cmd.fin_nop;
		end
	end

	// item, probe and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= {method_id, bci};
			all_q  <= (mode == MODE_INV_ALL);
			skip_q <= no_install;
		end
		if (cmd.probe_start) begin
			idx_q       <= base;
			emp_found_q <= 1'b0;
		end else if (cmd.walk_start) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else if (cmd.probe_step) begin
			idx_q <= idx_nxt;
			if (!emp_found_q && cur_empty) begin
				emp_found_q <= 1'b1;
				emp_idx_q   <= idx_q;
			end
			if (idx_q == base) begin
				evict_q <= rdata_q;
			end
		end else if (cmd.walk_step) begin
			idx_q <= idx_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.fin_hit || cmd.fin_miss || cmd.fin_walk || cmd.fin_nop) begin
			status_q   <= ST_INVAL;
			slot_q     <= '0;
			ev_valid_q <= 1'b0;
			ev_key_q   <= '0;
			count_q    <= '0;
			if (cmd.fin_hit) begin
				status_q <= ST_HIT;
				slot_q   <= SLOT_W'(idx_q);
			end else if (cmd.fin_miss) begin
				if (skip_q) begin
					status_q <= ST_SKIP;
				end else if (any_empty) begin
					status_q <= ST_INSTALL;
					slot_q   <= SLOT_W'(fill_idx);
				end else begin
					status_q   <= ST_REPLACE;
					slot_q     <= SLOT_W'(base);
					ev_valid_q <= 1'b1;
					ev_key_q   <= old_key;
				end
			end else if (cmd.fin_walk) begin
				count_q <= cnt_nxt;
			end
		end
	end

	assign done              = done_q;
	assign status            = status_q;
	assign slot              = slot_q;
	assign evicted_valid     = ev_valid_q;
	assign evicted_method    = ev_key_q[KEY_W-1:BCI_W];
	assign evicted_bci       = ev_key_q[BCI_W-1:0];
	assign invalidated_count = count_q;

endmodule

// ===== hw/rtl/phc_checker.sv =====
// port-level checks for the probed hash cache core, bound to the top level
module phc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [phc_pkg::STATUS_W-1:0] status,
	input logic [phc_pkg::SLOT_W-1:0]   slot,
	input logic                         evicted_valid,
	input logic [phc_pkg::CNT_W-1:0]    invalidated_count
);
	import phc_pkg::*;

	// an accepted item either keeps the core busy or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted item neither busy nor answered");

	// a result only follows work or an accept
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without an item");

	// eviction flag matches the replace status
	a_evict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (evicted_valid == (status == ST_REPLACE)))
		else $error("eviction flag disagrees with status");

	// lookups carry no invalidation count
	a_count_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_INVAL |-> invalidated_count == '0)
		else $error("count on a lookup result");

	// not-cached and invalidation answers report slot zero
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_SKIP || status == ST_INVAL) |-> slot == '0)
		else $error("nonzero slot on a result without a slot");

endmodule

bind probed_hash_cache_policy_core phc_checker u_phc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.done              (done),
	.status            (status),
	.slot              (slot),
	.evicted_valid     (evicted_valid),
	.invalidated_count (invalidated_count)
);
